@@ sv/leib_pkg.sv @@
// Shared types and constants for the line edit input buffer.
// No dependencies; used by leib_engine and line_edit_input_buffer_core.
package leib_pkg;

    // keystroke codes
    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_CTRL_P = 8'h10;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_MASK   = 8'h2A;
    localparam logic [7:0] KEY_DEL    = 8'h7F;

    // item kinds
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // echo_kind codes
    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_CHAR  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;

    // read_status codes
    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_DATA  = 2'd1;
    localparam logic [1:0] RD_EMPTY = 2'd2;
    localparam logic [1:0] RD_EOF   = 2'd3;

    localparam logic [7:0] ERASE_SAT = 8'hFF;

    typedef struct packed {
        logic [1:0] echo_kind;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       line_ready;
        logic       dump_request;
        logic [1:0] read_status;
        logic [7:0] read_data;
        logic       read_line_end;
    } leib_result_t;

endpackage

@@ sv/leib_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module leib_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/leib_engine.sv @@
// Edit/commit/read index engine: decodes items, drives the line store RAM
// and produces one result per item. Depends on leib_pkg.
module leib_engine #(
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     op,
    input  logic [7:0]               key,
    input  logic                     started,
    input  logic                     echo_en,
    input  logic [7:0]               rd_byte,
    output logic                     idle,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [7:0]               mem_wdata,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    output leib_pkg::leib_result_t   res,
    output logic                     res_valid
);

    localparam int unsigned SPAN = 2 * DEPTH;
    localparam int unsigned IW   = $clog2(SPAN);
    localparam int unsigned SW   = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_RDWAIT = 2'b10
    } state_t;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
        if (x == IW'(SPAN - 1)) return '0;
        return x + IW'(1);
    endfunction

    // distance modulo SPAN; SPAN need not be a power of two
    function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a,
                                               input logic [IW-1:0] b);
        if (a >= b) return a - b;
        return a + IW'(SPAN) - b;
    endfunction

    function automatic logic [SW-1:0] slot(input logic [IW-1:0] x);
        if (x >= IW'(DEPTH)) return SW'(x - IW'(DEPTH));
        return SW'(x);
    endfunction

    state_t        st_reg, st_next;
    logic [IW-1:0] read_reg, read_next;
    logic [IW-1:0] commit_reg, commit_next;
    logic [IW-1:0] edit_reg, edit_next;
    logic          started_reg, started_next;

    logic [IW-1:0] edit_inc;
    logic [IW-1:0] edit_dec;
    logic [IW-1:0] open_len;   // uncommitted characters
    logic [7:0]    cval;

    assign edit_inc  = idx_inc(edit_reg);
    assign edit_dec  = (edit_reg == '0) ? IW'(SPAN - 1) : edit_reg - IW'(1);
    assign open_len  = idx_diff(edit_reg, commit_reg);
    assign cval      = (key == leib_pkg::KEY_CR) ? leib_pkg::KEY_LF : key;
    assign mem_waddr = slot(edit_reg);
    assign mem_wdata = cval;
    assign mem_raddr = slot(read_reg);
    assign idle      = (st_reg == ST_IDLE);

    always_comb begin
        st_next      = st_reg;
        read_next    = read_reg;
        commit_next  = commit_reg;
        edit_next    = edit_reg;
        started_next = started_reg;
        res          = '0;
        res_valid    = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                if (start && op == leib_pkg::OP_KEY) begin
                    res_valid = 1'b1;
                    unique case (key) inside
                        leib_pkg::KEY_NUL: begin
                        end
                        leib_pkg::KEY_CTRL_P: begin
                            res.dump_request = 1'b1;
                        end
                        leib_pkg::KEY_CTRL_U: begin
                            // open line never holds LF (LF always commits),
                            // so kill erases the whole uncommitted run
                            if (open_len != '0) begin
                                res.echo_kind = leib_pkg::ECHO_ERASE;
                                res.erase_count = (32'(open_len) > 32'd255) ?
                                                  leib_pkg::ERASE_SAT : 8'(open_len);
                                edit_next = commit_reg;
                            end
                        end
                        leib_pkg::KEY_CTRL_H, leib_pkg::KEY_DEL: begin
                            if (open_len != '0) begin
                                res.echo_kind   = leib_pkg::ECHO_ERASE;
                                res.erase_count = 8'd1;
                                edit_next       = edit_dec;
                            end
                        end
                        default: begin
                            if (idx_diff(edit_reg, read_reg) < IW'(DEPTH)) begin
                                mem_we        = 1'b1;
                                edit_next     = edit_inc;
                                res.echo_kind = leib_pkg::ECHO_CHAR;
                                res.echo_char = (!echo_en && cval != leib_pkg::KEY_LF) ?
                                                leib_pkg::KEY_MASK : cval;
                                if (cval == leib_pkg::KEY_LF ||
                                    cval == leib_pkg::KEY_CTRL_D ||
                                    idx_diff(edit_inc, read_reg) == IW'(DEPTH)) begin
                                    commit_next    = edit_inc;
                                    res.line_ready = 1'b1;
                                end
                            end
                        end
                    endcase
                end else if (start) begin
                    if (read_reg == commit_reg) begin
                        res_valid       = 1'b1;
                        res.read_status = leib_pkg::RD_EMPTY;
                    end else begin
                        mem_re       = 1'b1;
                        started_next = started;
                        st_next      = ST_RDWAIT;
                    end
                end
            end
            ST_RDWAIT: begin
                res_valid = 1'b1;
                st_next   = ST_IDLE;
                if (rd_byte == leib_pkg::KEY_CTRL_D) begin
                    res.read_status = leib_pkg::RD_EOF;
                    if (!started_reg) read_next = idx_inc(read_reg);
                end else begin
                    read_next         = idx_inc(read_reg);
                    res.read_status   = leib_pkg::RD_DATA;
                    res.read_data     = rd_byte;
                    res.read_line_end = (rd_byte == leib_pkg::KEY_LF);
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            read_reg   <= '0;
            commit_reg <= '0;
            edit_reg   <= '0;
        end else begin
            st_reg     <= st_next;
            read_reg   <= read_next;
            commit_reg <= commit_next;
            edit_reg   <= edit_next;
        end
        started_reg <= started_next;
    end

    // fill level never exceeds the ring
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_diff(edit_reg, read_reg) <= IW'(DEPTH))
        else $error("edit index ran past read index");

    // commit lies between read and edit
    a_commit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_diff(commit_reg, read_reg) <= idx_diff(edit_reg, read_reg))
        else $error("commit index outside read..edit");

    // a RAM read is always followed by exactly one result
    a_rd_result: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |=> (st_reg == ST_RDWAIT && res_valid))
        else $error("read of line store produced no result");

endmodule

@@ sv/line_edit_input_buffer_core.sv @@
// Top level of the line edit input buffer: stream ports, config register,
// result register. Depends on leib_pkg, leib_engine and leib_ram.

// Keyboard line-editing buffer. Each s_ transaction is a keystroke (tuser 0)
// or a read of one committed byte (tuser 1) and yields exactly one m_
// transaction. Keystrokes, and reads that find nothing committed, answer in
// the cycle taken; a read that pops a byte waits in ST_RDWAIT for the RAM's
// registered read data. The block holds one item at a time and takes the next
// one in the cycle its result register is emptied or empty. The line store
// has no reset or clearing pass; only echo_enable, m_tvalid, the engine state
// and the ring indices reset. echo_enable is written over cfg_valid/cfg_data
// (always ready), and should be changed only while no item is in flight.
module line_edit_input_buffer_core #(
    parameter int unsigned BUFFER_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key_code, [8] read_started, [15:9] zero
    input  logic        s_tuser,   // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] echo_kind, [9:2] echo_char, [17:10] erase_count, [18] line_ready,
    // [19] dump_request, [21:20] read_status, [29:22] read_data,
    // [30] read_line_end, [31] zero
    output logic [31:0] m_tdata,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data   // [0] echo_enable
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    logic                  echo_en_reg;
    logic                  m_valid_reg, m_valid_next;
    leib_pkg::leib_result_t m_res_reg;

    logic                  eng_idle;
    logic                  accept;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [7:0]            mem_wdata, mem_rdata;
    leib_pkg::leib_result_t eng_res;
    logic                  eng_res_valid;

    // accept only when idle and the result register is free this edge
    assign s_tready  = eng_idle && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    leib_engine #(
        .DEPTH (BUFFER_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .op        (s_tuser),
        .key       (s_tdata[7:0]),
        .started   (s_tdata[8]),
        .echo_en   (echo_en_reg),
        .rd_byte   (mem_rdata),
        .idle      (eng_idle),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .res       (eng_res),
        .res_valid (eng_res_valid)
    );

    leib_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (eng_res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            echo_en_reg <= 1'b1;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                echo_en_reg <= cfg_data[0];
            end
        end
        if (eng_res_valid) begin
            m_res_reg <= eng_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0,
                       m_res_reg.read_line_end,
                       m_res_reg.read_data,
                       m_res_reg.read_status,
                       m_res_reg.dump_request,
                       m_res_reg.line_ready,
                       m_res_reg.erase_count,
                       m_res_reg.echo_char,
                       m_res_reg.echo_kind};

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_res_valid |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

    // every accepted item that pops a byte delivers its result next cycle
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !eng_res_valid) |=> eng_res_valid)
        else $error("read result did not follow RAM latency");

endmodule

@@ tb/sv/line_edit_input_buffer_core_tb.sv @@
// Self-checking testbench for line_edit_input_buffer_core: directed and random
// keystroke/read transactions, checked against an in-bench line discipline model.
// Depends on leib_pkg and the line_edit_input_buffer_core RTL.
module line_edit_input_buffer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH            = 128;
    localparam int IDX_W            = $clog2(2 * DEPTH);
    localparam int RANDOM_PER_PHASE = 600;
    localparam int STALL_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 8;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic       op;
        logic [7:0] key;
        logic       started;
    } tty_item_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [7:0] key_code, [8] read_started, [15:9] zero
    logic        s_tuser   = 1'b0; // [0] opcode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // see unpack_result for the field layout
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data  = '0;   // [0] echo_enable

    // line discipline model state
    logic [7:0] ring [DEPTH] = '{default: '0};
    idx_t       read_idx   = '0;
    idx_t       commit_idx = '0;
    idx_t       edit_idx   = '0;
    logic       echo_on    = 1'b1;

    tty_item_t              input_items[$];
    leib_pkg::leib_result_t due_responses[$];
    tty_item_t              offered;
    logic                   s_taken        = 1'b0;
    int unsigned            items_queued   = 0;
    int unsigned            send_idle_pct  = 0;
    int unsigned            recv_idle_pct  = 0;
    int unsigned            mismatch_count = 0;
    int unsigned            stall_cycles   = 0;

    line_edit_input_buffer_core #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [IDX_W-2:0] ring_slot(idx_t i);
        return i[IDX_W-2:0];
    endfunction

    // entries between reader and writer, modulo twice the depth
    function automatic idx_t fill_level(idx_t hi, idx_t lo);
        return idx_t'(hi - lo);
    endfunction

    // one keystroke or read against the model state
    function automatic leib_pkg::leib_result_t line_discipline_step(tty_item_t it);
        leib_pkg::leib_result_t r;
        logic [7:0]             c;
        int unsigned            n;
        r = '0;
        if (it.op == leib_pkg::OP_KEY) begin
            if (it.key == leib_pkg::KEY_CTRL_P) begin
                r.dump_request = 1'b1;
            end else if (it.key == leib_pkg::KEY_CTRL_U) begin
                n = 0;
                while (edit_idx != commit_idx &&
                       ring[ring_slot(edit_idx - 1'b1)] != leib_pkg::KEY_LF) begin
                    edit_idx = edit_idx - 1'b1;
                    n++;
                end
                if (n > 0) begin
                    r.echo_kind   = leib_pkg::ECHO_ERASE;
                    r.erase_count = (n > 255) ? leib_pkg::ERASE_SAT : n[7:0];
                end
            end else if (it.key == leib_pkg::KEY_CTRL_H || it.key == leib_pkg::KEY_DEL) begin
                if (edit_idx != commit_idx) begin
                    edit_idx      = edit_idx - 1'b1;
                    r.echo_kind   = leib_pkg::ECHO_ERASE;
                    r.erase_count = 8'd1;
                end
            end else if (it.key != leib_pkg::KEY_NUL &&
                         fill_level(edit_idx, read_idx) < DEPTH) begin
                c = (it.key == leib_pkg::KEY_CR) ? leib_pkg::KEY_LF : it.key;
                ring[ring_slot(edit_idx)] = c;
                edit_idx    = edit_idx + 1'b1;
                r.echo_kind = leib_pkg::ECHO_CHAR;
                r.echo_char = (!echo_on && c != leib_pkg::KEY_LF) ? leib_pkg::KEY_MASK : c;
                // LF, Ctrl-D or a full ring hands the line to readers
                if (c == leib_pkg::KEY_LF || c == leib_pkg::KEY_CTRL_D ||
                    fill_level(edit_idx, read_idx) == DEPTH) begin
                    commit_idx   = edit_idx;
                    r.line_ready = 1'b1;
                end
            end
        end else begin
            if (read_idx == commit_idx) begin
                r.read_status = leib_pkg::RD_EMPTY;
            end else begin
                c = ring[ring_slot(read_idx)];
                if (c == leib_pkg::KEY_CTRL_D) begin
                    // put back when the read call already returned bytes
                    if (!it.started)
                        read_idx = read_idx + 1'b1;
                    r.read_status = leib_pkg::RD_EOF;
                end else begin
                    read_idx        = read_idx + 1'b1;
                    r.read_status   = leib_pkg::RD_DATA;
                    r.read_data     = c;
                    r.read_line_end = (c == leib_pkg::KEY_LF);
                end
            end
        end
        return r;
    endfunction

    function automatic leib_pkg::leib_result_t unpack_result(logic [31:0] d);
        leib_pkg::leib_result_t r;
        r.echo_kind     = d[1:0];
        r.echo_char     = d[9:2];
        r.erase_count   = d[17:10];
        r.line_ready    = d[18];
        r.dump_request  = d[19];
        r.read_status   = d[21:20];
        r.read_data     = d[29:22];
        r.read_line_end = d[30];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task automatic queue_item(input logic op, input logic [7:0] key, input logic started);
        tty_item_t it;
        it.op      = op;
        it.key     = key;
        it.started = started;
        input_items.push_back(it);
        items_queued++;
    endtask

    // mostly printable text, sometimes any nonzero byte (controls included)
    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic queue_directed();
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_NUL, 1'b0);       // ignored key
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_P, 1'b1);    // dump request only
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_H, 1'b0);    // backspace, empty line
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_U, 1'b0);    // kill, nothing to erase
        queue_item(leib_pkg::OP_READ, 8'hFF, 1'b0);                  // nothing committed
        queue_item(leib_pkg::OP_KEY, 8'h61, 1'b0);
        queue_item(leib_pkg::OP_KEY, 8'hFF, 1'b1);
        queue_item(leib_pkg::OP_KEY, 8'h80, 1'b0);
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_H, 1'b1);
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_DEL, 1'b0);
        queue_item(leib_pkg::OP_KEY, 8'h78, 1'b0);
        queue_item(leib_pkg::OP_KEY, 8'h79, 1'b0);
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_U, 1'b1);    // erases three
        queue_item(leib_pkg::OP_KEY, 8'h7E, 1'b0);
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CR, 1'b0);        // stored and committed as LF
        queue_item(leib_pkg::OP_READ, 8'h00, 1'b0);
        queue_item(leib_pkg::OP_READ, 8'hFF, 1'b1);                  // line end
        queue_item(leib_pkg::OP_READ, 8'h00, 1'b1);                  // empty again
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_D, 1'b0);    // commits on its own
        queue_item(leib_pkg::OP_READ, 8'h00, 1'b1);                  // end of file, put back
        queue_item(leib_pkg::OP_READ, 8'h00, 1'b0);                  // end of file, consumed
        queue_item(leib_pkg::OP_READ, 8'h00, 1'b0);
        queue_item(leib_pkg::OP_KEY, 8'h01, 1'b0);
        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_LF, 1'b1);
        queue_item(leib_pkg::OP_READ, 8'h55, 1'b0);
        queue_item(leib_pkg::OP_READ, 8'hAA, 1'b1);
    endtask

    // typed lines, read calls and a little noise; long lines fill the ring
    task automatic queue_random(input int unsigned count);
        int unsigned target;
        int unsigned roll;
        int unsigned len;
        target = items_queued + count;
        while (items_queued < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                len = ($urandom_range(0, 99) < 8) ? $urandom_range(100, 140)
                                                  : $urandom_range(0, 16);
                for (int i = 0; i < len; i++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 6)
                        queue_item(leib_pkg::OP_KEY,
                                   roll[0] ? leib_pkg::KEY_CTRL_H : leib_pkg::KEY_DEL,
                                   1'($urandom));
                    else if (roll < 8)
                        queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_U, 1'($urandom));
                    else
                        queue_item(leib_pkg::OP_KEY, text_char(), 1'($urandom));
                end
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_LF, 1'($urandom));
                else if (roll < 75)
                    queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CR, 1'($urandom));
                else if (roll < 90)
                    queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_D, 1'($urandom));
            end else if (roll < 85) begin
                // one read call: the first pop has delivered nothing yet
                len = $urandom_range(1, 40);
                for (int i = 0; i < len; i++)
                    queue_item(leib_pkg::OP_READ, 8'($urandom), i != 0);
            end else if (roll < 93) begin
                queue_item(1'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                case ($urandom_range(0, 4))
                    0: queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_P, 1'($urandom));
                    1: queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_U, 1'($urandom));
                    2: queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_CTRL_H, 1'($urandom));
                    3: queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_DEL, 1'($urandom));
                    default: queue_item(leib_pkg::OP_KEY, leib_pkg::KEY_NUL, 1'($urandom));
                endcase
            end
        end
    endtask

    task automatic wait_for_idle();
        forever begin
            @(posedge aclk);
            #1;
            if (input_items.size() == 0 && !s_tvalid && due_responses.size() == 0)
                break;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_echo_enable(input logic value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // driver: new transaction once the current one is taken or none is up
    always @(negedge aclk) begin
        if (!s_tvalid || s_taken) begin
            if (input_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offered = input_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= offered.op;
                s_tdata  <= {7'b0, offered.started, offered.key};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor, model update and watchdog
    always @(posedge aclk) begin
        leib_pkg::leib_result_t got;
        leib_pkg::leib_result_t want;
        // a result never belongs to the item taken on the same edge: pop first
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata);
            if (due_responses.size() == 0) begin
                report_mismatch("result transaction with nothing due");
            end else begin
                want = due_responses.pop_front();
                check_field("echo_kind", 8'(got.echo_kind), 8'(want.echo_kind));
                check_field("echo_char", got.echo_char, want.echo_char);
                check_field("erase_count", got.erase_count, want.erase_count);
                check_field("line_ready", 8'(got.line_ready), 8'(want.line_ready));
                check_field("dump_request", 8'(got.dump_request), 8'(want.dump_request));
                check_field("read_status", 8'(got.read_status), 8'(want.read_status));
                check_field("read_data", got.read_data, want.read_data);
                check_field("read_line_end", 8'(got.read_line_end), 8'(want.read_line_end));
            end
        end
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken)
            due_responses.push_back(line_discipline_step(offered));
        if (aresetn && cfg_valid && cfg_ready)
            echo_on = cfg_data[0];

        if (s_taken || (aresetn && ((m_tvalid && m_tready) || (cfg_valid && cfg_ready))))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 6;
        recv_idle_pct = 78;
        write_echo_enable(1'b1);
        queue_directed();
        wait_for_idle();
        write_echo_enable(1'b0);
        queue_random(RANDOM_PER_PHASE);
        wait_for_idle();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 78;
        recv_idle_pct = 6;
        write_echo_enable(1'b1);
        queue_random(RANDOM_PER_PHASE);
        wait_for_idle();

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_echo_enable(1'b0);
        queue_random(RANDOM_PER_PHASE);
        wait_for_idle();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
sv/leib_pkg.sv
sv/leib_ram.sv
sv/leib_engine.sv
sv/line_edit_input_buffer_core.sv
tb/sv/line_edit_input_buffer_core_tb.sv
